[hdl/tiht_pkg.sv]
// ----------------------------------------------------------------------------
// tiht_pkg
// Types and codes shared by the input history table modules.
// ----------------------------------------------------------------------------
package tiht_pkg;

	localparam int PID_W   = 4;
	localparam int STAMP_W = 32;
	localparam int CHG_W   = 13;
	localparam int FIDX_W  = 9;
	localparam int PCNT_W  = 10;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 8;

	localparam logic [2:0] MODE_INSERT  = 3'd0;
	localparam logic [2:0] MODE_PREDICT = 3'd1;
	localparam logic [2:0] MODE_DISC_P  = 3'd2;
	localparam logic [2:0] MODE_DISC_A  = 3'd3;
	localparam logic [2:0] MODE_FIND    = 3'd4;
	localparam logic [2:0] MODE_MARK    = 3'd5;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_LOCKED = 2'd2;
	localparam logic [1:0] ST_SKIP   = 2'd3;

	localparam logic [1:0] MARK_CONFIRMED = 2'd0;
	localparam logic [1:0] MARK_PREDICTED = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_CONNECTED = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_LOCAL     = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_HOLD      = 2'd2;

	typedef struct packed {
		logic signed [STAMP_W-1:0] stamp;
		logic [7:0]                key;
		logic signed [7:0]         ax;
		logic signed [7:0]         ay;
		logic [1:0]                mods;
		logic [1:0]                mark;
		logic                      applied;
	} entry_t;

	typedef struct packed {
		logic [7:0] connected_mask;
		logic [2:0] local_player;
		logic       hold_predictions;
	} cfg_t;

	typedef struct packed {
		logic [2:0]                mode;
		logic [2:0]                player;
		logic signed [STAMP_W-1:0] stamp;
		logic signed [STAMP_W-1:0] predict_delta;
		logic [7:0]                key_code;
		logic signed [7:0]         axis_x;
		logic signed [7:0]         axis_y;
		logic [1:0]                modifier_bits;
		logic [1:0]                mark;
	} req_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [CHG_W-1:0]          changed_count;
		logic                      found;
		logic [FIDX_W-1:0]         found_index;
		logic signed [STAMP_W-1:0] found_stamp;
		logic [7:0]                found_key;
		logic signed [7:0]         found_axis_x;
		logic signed [7:0]         found_axis_y;
		logic [1:0]                found_modifiers;
		logic [PCNT_W-1:0]         player_count_after;
	} res_t;

endpackage

[hdl/tiht_if.sv]
// ----------------------------------------------------------------------------
// tiht_if
// Request and response channels of the input history table.
// ----------------------------------------------------------------------------
interface tiht_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        mode;
	logic [2:0]        player;
	logic signed [31:0] stamp;
	logic signed [31:0] predict_delta;
	logic [7:0]        key_code;
	logic signed [7:0] axis_x;
	logic signed [7:0] axis_y;
	logic [1:0]        modifier_bits;
	logic [1:0]        mark;

	modport source(output valid, mode, player, stamp, predict_delta, key_code, axis_x,
		axis_y, modifier_bits, mark, input ready);
	modport sink(input valid, mode, player, stamp, predict_delta, key_code, axis_x,
		axis_y, modifier_bits, mark, output ready);
endinterface

interface tiht_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [12:0]        changed_count;
	logic               found;
	logic [8:0]         found_index;
	logic signed [31:0] found_stamp;
	logic [7:0]         found_key;
	logic signed [7:0]  found_axis_x;
	logic signed [7:0]  found_axis_y;
	logic [1:0]         found_modifiers;
	logic [9:0]         player_count_after;

	modport source(output valid, status, changed_count, found, found_index, found_stamp,
		found_key, found_axis_x, found_axis_y, found_modifiers, player_count_after,
		input ready);
	modport sink(input valid, status, changed_count, found, found_index, found_stamp,
		found_key, found_axis_x, found_axis_y, found_modifiers, player_count_after,
		output ready);
endinterface

[hdl/tiht_alu.sv]
// ----------------------------------------------------------------------------
// tiht_alu
// Shared timestamp unit: wrapping sum and signed compare.
// ----------------------------------------------------------------------------
module tiht_alu (
	input  logic signed [tiht_pkg::STAMP_W-1:0] a,
	input  logic signed [tiht_pkg::STAMP_W-1:0] b,
	output logic signed [tiht_pkg::STAMP_W-1:0] sum,
	output logic                                lt,
	output logic                                eq
);
	import tiht_pkg::*;

	assign sum = a + b;
	assign lt  = a < b;
	assign eq  = a == b;

endmodule

[hdl/tiht_engine.sv]
// ----------------------------------------------------------------------------
// tiht_engine
// Sequencer over the history memory: scan, shift, compact and search.
// ----------------------------------------------------------------------------
module tiht_engine #(
	parameter int PLAYERS = 8,
	parameter int DEPTH   = 512
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tiht_pkg::cfg_t cfg,
	input  logic           start,
	input  tiht_pkg::req_t req,
	output logic           idle,
	input  logic           res_free,
	output logic           res_valid,
	output tiht_pkg::res_t res
);
	import tiht_pkg::*;

	localparam int PW = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = PW + IW;

	typedef enum logic [4:0] {
		S_IDLE, S_LOOP, S_PR_GET, S_INS_SCAN, S_INS_CHK, S_INS_DEC, S_SH_SCAN, S_SH_WR,
		S_INS_WR, S_P_NEXT, S_DC_SCAN, S_DC_CHK, S_FD_SCAN, S_FD_CHK, S_MK_SCAN,
		S_MK_CHK, S_FIN, S_RESP
	} state_t;

	state_t                    state_q;
	logic [2:0]                op_q;
	logic [2:0]                in_p_q;
	logic [PID_W-1:0]          cur_p_q;
	entry_t                    f_q;
	logic signed [STAMP_W-1:0] delta_q;
	logic [1:0]                status_q;
	logic [CHG_W-1:0]          changed_q;
	logic                      found_q;
	logic [CW-1:0]             fidx_q;
	entry_t                    fent_q;
	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             j_q;
	logic [CW-1:0]             w_q;
	logic [CW-1:0]             cnt_q [PLAYERS];

	entry_t                    mem [2**AW];
	entry_t                    rd_q;
	logic                      mem_re;
	logic                      mem_we;
	logic [AW-1:0]             raddr;
	logic [AW-1:0]             waddr;
	entry_t                    wdata;

	logic [PW-1:0]             pid;
	logic [CW-1:0]             n;
	logic [CW-1:0]             nm1;
	logic [CW-1:0]             jm1;
	logic signed [STAMP_W-1:0] alu_b;
	logic signed [STAMP_W-1:0] alu_sum;
	logic                      alu_lt;
	logic                      alu_eq;
	logic                      keep;

	function automatic logic elig(input logic [PID_W-1:0] p, input cfg_t c);
		return (p < PID_W'(PLAYERS)) && c.connected_mask[p[2:0]] &&
			(p[2:0] != c.local_player);
	endfunction

	assign pid  = cur_p_q[PW-1:0];
	assign n    = cnt_q[pid];
	assign nm1  = n - CW'(1);
	assign jm1  = j_q - CW'(1);
	assign keep = !(!rd_q.applied && rd_q.mark == MARK_PREDICTED);
	assign idle = state_q == S_IDLE;

	assign alu_b = (state_q == S_PR_GET) ? delta_q : f_q.stamp;

	tiht_alu u_alu (
		.a   (rd_q.stamp),
		.b   (alu_b),
		.sum (alu_sum),
		.lt  (alu_lt),
		.eq  (alu_eq)
	);

	always_comb begin
		mem_re = 1'b0;
		mem_we = 1'b0;
		raddr  = {pid, idx_q[IW-1:0]};
		waddr  = {pid, idx_q[IW-1:0]};
		wdata  = rd_q;
		case (state_q)
			S_LOOP: begin
				mem_re = 1'b1;
				raddr  = {pid, nm1[IW-1:0]};
			end
			S_INS_SCAN, S_DC_SCAN, S_FD_SCAN, S_MK_SCAN: begin
				mem_re = 1'b1;
			end
			S_SH_SCAN: begin
				mem_re = 1'b1;
				raddr  = {pid, jm1[IW-1:0]};
			end
			S_SH_WR: begin
				mem_we = 1'b1;
				waddr  = {pid, j_q[IW-1:0]};
			end
			S_INS_WR: begin
				mem_we = 1'b1;
				wdata  = f_q;
			end
			S_DC_CHK: begin
				mem_we = keep;
				waddr  = {pid, w_q[IW-1:0]};
			end
			S_MK_CHK: begin
				mem_we        = alu_eq;
				wdata.applied = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rd_q <= mem[raddr];
		end
	end

	always_comb begin
		res.status             = status_q;
		res.changed_count      = changed_q;
		res.found              = found_q;
		res.found_index        = found_q ? FIDX_W'(fidx_q) : '0;
		res.found_stamp        = found_q ? fent_q.stamp : '0;
		res.found_key          = found_q ? fent_q.key : '0;
		res.found_axis_x       = found_q ? fent_q.ax : '0;
		res.found_axis_y       = found_q ? fent_q.ay : '0;
		res.found_modifiers    = found_q ? fent_q.mods : '0;
		res.player_count_after = (cur_p_q < PID_W'(PLAYERS)) ? PCNT_W'(n) : '0;
	end

	assign res_valid = (state_q == S_RESP) && res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= MODE_INSERT;
			in_p_q    <= '0;
			cur_p_q   <= '0;
			status_q  <= ST_SKIP;
			changed_q <= '0;
			found_q   <= 1'b0;
			idx_q     <= '0;
			j_q       <= '0;
			w_q       <= '0;
			fidx_q    <= '0;
			for (int k = 0; k < PLAYERS; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= req.mode;
						in_p_q    <= req.player;
						cur_p_q   <= {1'b0, req.player};
						delta_q   <= req.predict_delta;
						status_q  <= ST_SKIP;
						changed_q <= '0;
						found_q   <= 1'b0;
						idx_q     <= '0;
						w_q       <= '0;
						f_q.stamp   <= req.stamp;
						f_q.key     <= req.key_code;
						f_q.ax      <= req.axis_x;
						f_q.ay      <= req.axis_y;
						f_q.mods    <= req.modifier_bits;
						f_q.mark    <= req.mark;
						f_q.applied <= 1'b0;
						state_q     <= S_FIN;
						case (req.mode)
							MODE_INSERT: begin
								if ({1'b0, req.player} < PID_W'(PLAYERS)) begin
									state_q <= S_INS_SCAN;
								end
							end
							MODE_PREDICT, MODE_DISC_A: begin
								if (!cfg.hold_predictions) begin
									status_q <= ST_DONE;
									cur_p_q  <= '0;
									state_q  <= S_LOOP;
								end
							end
							MODE_DISC_P: begin
								if (!cfg.hold_predictions && elig({1'b0, req.player}, cfg)) begin
									status_q <= ST_DONE;
									state_q  <= S_DC_SCAN;
								end
							end
							MODE_FIND: begin
								if ({1'b0, req.player} < PID_W'(PLAYERS)) begin
									state_q <= S_FD_SCAN;
								end
							end
							MODE_MARK: begin
								if ({1'b0, req.player} < PID_W'(PLAYERS)) begin
									state_q <= S_MK_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_LOOP: begin
					idx_q <= '0;
					w_q   <= '0;
					if (cur_p_q >= PID_W'(PLAYERS)) begin
						state_q <= S_FIN;
					end else if (!elig(cur_p_q, cfg)) begin
						cur_p_q <= cur_p_q + PID_W'(1);
					end else if (op_q == MODE_DISC_A) begin
						state_q <= S_DC_SCAN;
					end else if (n == '0) begin
						cur_p_q <= cur_p_q + PID_W'(1);
					end else begin
						state_q <= S_PR_GET;
					end
				end
				S_PR_GET: begin
					// The predicted frame carries the last frame's axes only.
					f_q.stamp   <= alu_sum;
					f_q.key     <= '0;
					f_q.ax      <= rd_q.ax;
					f_q.ay      <= rd_q.ay;
					f_q.mods    <= '0;
					f_q.mark    <= MARK_PREDICTED;
					f_q.applied <= 1'b0;
					state_q     <= S_INS_SCAN;
				end
				S_INS_SCAN: begin
					state_q <= (idx_q < n) ? S_INS_CHK : S_INS_DEC;
				end
				S_INS_CHK: begin
					if (alu_lt) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_INS_SCAN;
					end else if (alu_eq) begin
						if (rd_q.mark == MARK_CONFIRMED || rd_q.applied) begin
							if (op_q == MODE_INSERT) begin
								status_q <= ST_LOCKED;
							end
							state_q <= S_P_NEXT;
						end else begin
							state_q <= S_INS_WR;
						end
					end else begin
						state_q <= S_INS_DEC;
					end
				end
				S_INS_DEC: begin
					if (n >= CW'(DEPTH)) begin
						if (op_q == MODE_INSERT) begin
							status_q <= ST_FULL;
						end
						state_q <= S_P_NEXT;
					end else begin
						j_q        <= n;
						cnt_q[pid] <= n + CW'(1);
						changed_q  <= changed_q + CHG_W'(1);
						state_q    <= S_SH_SCAN;
					end
				end
				S_SH_SCAN: begin
					state_q <= (j_q > idx_q) ? S_SH_WR : S_INS_WR;
				end
				S_SH_WR: begin
					j_q     <= jm1;
					state_q <= S_SH_SCAN;
				end
				S_INS_WR: begin
					if (op_q == MODE_INSERT) begin
						status_q <= ST_DONE;
					end
					state_q <= S_P_NEXT;
				end
				S_P_NEXT: begin
					if (op_q == MODE_PREDICT || op_q == MODE_DISC_A) begin
						cur_p_q <= cur_p_q + PID_W'(1);
						state_q <= S_LOOP;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DC_SCAN: begin
					if (idx_q < n) begin
						state_q <= S_DC_CHK;
					end else begin
						cnt_q[pid] <= w_q;
						changed_q  <= changed_q + CHG_W'(n - w_q);
						state_q    <= S_P_NEXT;
					end
				end
				S_DC_CHK: begin
					if (keep) begin
						w_q <= w_q + CW'(1);
					end
					idx_q   <= idx_q + CW'(1);
					state_q <= S_DC_SCAN;
				end
				S_FD_SCAN: begin
					state_q <= (idx_q < n) ? S_FD_CHK : S_FIN;
				end
				S_FD_CHK: begin
					if (rd_q.applied) begin
						found_q  <= 1'b1;
						fidx_q   <= idx_q;
						fent_q   <= rd_q;
						status_q <= ST_DONE;
					end
					idx_q   <= idx_q + CW'(1);
					state_q <= S_FD_SCAN;
				end
				S_MK_SCAN: begin
					state_q <= (idx_q < n) ? S_MK_CHK : S_FIN;
				end
				S_MK_CHK: begin
					if (alu_eq) begin
						status_q <= ST_DONE;
						state_q  <= S_FIN;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_MK_SCAN;
					end
				end
				S_FIN: begin
					cur_p_q <= {1'b0, in_p_q};
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SH_WR || state_q == S_INS_WR ||
			state_q == S_DC_CHK || state_q == S_MK_CHK))
		else $error("history write outside a write step");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SH_WR) |-> (j_q > idx_q && j_q < CW'(DEPTH)))
		else $error("shift writes outside the open tail");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DC_CHK) |-> (w_q <= idx_q))
		else $error("compaction write overtook its read");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == S_IDLE) |=> (state_q != S_IDLE))
		else $error("accepted item did not start the sequencer");

endmodule

[hdl/timestamped_input_history_table.sv]
// ----------------------------------------------------------------------------
// timestamped_input_history_table
// Per-player input frame histories kept sorted by timestamp.
// ----------------------------------------------------------------------------
// The req channel takes one operation item (insert, predict all, discard
// player, discard all, find applied, mark applied); the rsp channel returns
// exactly one result item for each. Configuration registers are written on
// cfg_we with cfg_index and cfg_data; the user must write them only while
// no operation is in flight, as the block itself does not enforce this.
// Every operation runs on one sequencer that walks the history memory, which
// has one read and one write port; each entry visited takes a registered
// read, then a compare or write back. Predict all and discard all walk the
// eligible players in turn. req.ready is high only while the sequencer is
// idle. A finished result sits in the rsp register; if the receiver stalls,
// the next operation still runs and waits at its end until that register is
// free. Reset clears the frame counts, the configuration and the rsp valid
// flag; memory contents are never used before being written.
// ----------------------------------------------------------------------------
module timestamped_input_history_table #(
	parameter int PLAYERS = 8,
	parameter int DEPTH   = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tiht_req_if.sink                       req,
	tiht_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [tiht_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [tiht_pkg::CDATA_W-1:0]   cfg_data
);
	import tiht_pkg::*;

	cfg_t cfg_q;
	req_t req_d;
	res_t res_d;
	res_t rsp_q;
	logic rsp_valid_q;
	logic idle;
	logic res_free;
	logic res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CONNECTED: cfg_q.connected_mask   <= cfg_data;
				CFG_LOCAL:     cfg_q.local_player     <= cfg_data[2:0];
				CFG_HOLD:      cfg_q.hold_predictions <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		req_d.mode          = req.mode;
		req_d.player        = req.player;
		req_d.stamp         = req.stamp;
		req_d.predict_delta = req.predict_delta;
		req_d.key_code      = req.key_code;
		req_d.axis_x        = req.axis_x;
		req_d.axis_y        = req.axis_y;
		req_d.modifier_bits = req.modifier_bits;
		req_d.mark          = req.mark;
	end

	assign req.ready = idle;
	assign res_free  = !rsp_valid_q || rsp.ready;

	tiht_engine #(
		.PLAYERS (PLAYERS),
		.DEPTH   (DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (req.valid),
		.req       (req_d),
		.idle      (idle),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res_d;
		end
	end

	assign rsp.valid              = rsp_valid_q;
	assign rsp.status             = rsp_q.status;
	assign rsp.changed_count      = rsp_q.changed_count;
	assign rsp.found              = rsp_q.found;
	assign rsp.found_index        = rsp_q.found_index;
	assign rsp.found_stamp        = rsp_q.found_stamp;
	assign rsp.found_key          = rsp_q.found_key;
	assign rsp.found_axis_x       = rsp_q.found_axis_x;
	assign rsp.found_axis_y       = rsp_q.found_axis_y;
	assign rsp.found_modifiers    = rsp_q.found_modifiers;
	assign rsp.player_count_after = rsp_q.player_count_after;

endmodule
